[src/mbb_pkg.sv]
// Shared types and constants for the clipped monochrome bitmap blit.
// Command codes, register indexes, controller states and the structs passed
// between the source walker and the top level. No dependencies.
package mbb_pkg;

  localparam int DEST_BYTES_DEF = 8192;
  localparam int MAX_WIDTH_DEF  = 512;
  localparam int MAX_HEIGHT_DEF = 128;

  // copy_width and copy_height clamp here
  localparam logic [9:0] COPY_LIMIT = 10'd512;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_SOURCE  = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEST_WIDTH  = 3'd0,
    REG_DEST_HEIGHT = 3'd1,
    REG_COPY_WIDTH  = 3'd2,
    REG_COPY_HEIGHT = 3'd3,
    REG_POS_X       = 3'd4,
    REG_POS_Y       = 3'd5
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_RD0,
    ST_MW0,
    ST_MW1,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [9:0] dest_width;
    logic [7:0] dest_height;
    logic [9:0] copy_width;
    logic [9:0] copy_height;
    logic [9:0] pos_x;   // two's complement
    logic [9:0] pos_y;   // two's complement
  } cfg_t;

  // One source word mapped onto the two destination bytes it can touch.
  typedef struct packed {
    logic [7:0]  mask0;
    logic [7:0]  bits0;
    logic [7:0]  mask1;
    logic [7:0]  bits1;
    logic [15:0] row_off;  // destination row times stride
    logic [7:0]  col0;     // byte column of first byte (valid when mask0 set)
    logic [7:0]  col1;     // byte column of second byte (valid when mask1 set)
    logic        done;     // this word closed the copy
  } pix_t;

endpackage

[src/mbb_dest_ram.sv]
// Destination bitmap storage: one write port, one read port, registered
// read data. Depends on nothing.
module mbb_dest_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/mbb_src_walk.sv]
// Source position counters and pixel mapping: turns one source word into
// masks and bits for two destination bytes plus the row offset.
// Depends on mbb_pkg.
module mbb_src_walk
  import mbb_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       step,
  input  logic       restart,
  input  logic [7:0] data,
  output pix_t       pix
);

  logic [5:0]  bir_r, bir_nxt;
  logic [8:0]  row_r, row_nxt;
  pix_t        pix_r, pix_nxt;

  logic [9:0]  dw, cw, ch, rows;
  logic [7:0]  dh;
  logic [10:0] dw_round;
  logic [7:0]  stride;
  logic [6:0]  bpr;
  logic [11:0] dx0, dy, dx;
  logic [8:0]  col, base;
  logic        row_ok, last_byte, last_row;
  logic [7:0]  vld;
  logic [15:0] win_m, win_d;

  always_comb begin
    dw = (32'(cfg.dest_width) > MAX_WIDTH) ? 10'(MAX_WIDTH) : cfg.dest_width;
    dh = (32'(cfg.dest_height) > MAX_HEIGHT) ? 8'(MAX_HEIGHT) : cfg.dest_height;
    cw = (cfg.copy_width > COPY_LIMIT) ? COPY_LIMIT : cfg.copy_width;
    ch = (cfg.copy_height > COPY_LIMIT) ? COPY_LIMIT : cfg.copy_height;

    // rows padded to 32-bit words
    dw_round = {1'b0, dw} + 11'd31;
    stride   = {dw_round[10:5], 2'b00};

    bpr = 7'(({1'b0, cw} + 11'd7) >> 3);
    if (bpr == 7'd0) begin
      bpr = 7'd1;
    end
    rows = (ch == 10'd0) ? 10'd1 : ch;

    dx0 = {{2{cfg.pos_x[9]}}, cfg.pos_x} + {3'b000, bir_r, 3'b000};
    dy  = {{2{cfg.pos_y[9]}}, cfg.pos_y} + {3'b000, row_r};

    row_ok = ({1'b0, row_r} < ch) && !dy[11] && (dy < {4'b0000, dh});

    // vld[7] is the leftmost pixel of the word
    for (int b = 0; b < 8; b++) begin
      col = {bir_r, 3'b000} + 9'(b);
      dx  = dx0 + 12'(b);
      vld[7-b] = row_ok && ({1'b0, col} < cw) && !dx[11] && (dx < {2'b00, dw});
    end

    win_m = {vld, 8'h00} >> dx0[2:0];
    win_d = {data, 8'h00} >> dx0[2:0];
    base  = dx0[11:3];

    last_byte = ({1'b0, bir_r} + 7'd1) >= bpr;
    last_row  = ({1'b0, row_r} + 10'd1) >= rows;

    pix_nxt.mask0   = win_m[15:8];
    pix_nxt.bits0   = win_d[15:8];
    pix_nxt.mask1   = win_m[7:0];
    pix_nxt.bits1   = win_d[7:0];
    pix_nxt.row_off = dy[7:0] * stride;
    pix_nxt.col0    = base[7:0];
    pix_nxt.col1    = 8'(base + 9'd1);
    pix_nxt.done    = last_byte && last_row;

    bir_nxt = bir_r;
    row_nxt = row_r;
    if (restart) begin
      bir_nxt = '0;
      row_nxt = '0;
    end else if (step) begin
      if (last_byte) begin
        bir_nxt = '0;
        row_nxt = last_row ? 9'd0 : row_r + 9'd1;
      end else begin
        bir_nxt = bir_r + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bir_r <= '0;
      row_r <= '0;
    end else begin
      bir_r <= bir_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pix_r <= pix_nxt;
    end
  end

  assign pix = pix_r;

endmodule

[src/mono_bitmap_clipped_blit.sv]
// Top level of the clipped monochrome bitmap blit: stream ports, config
// registers, controller and output register. Depends on mbb_pkg,
// mbb_dest_ram and mbb_src_walk.
//
//   channel | dir | tdata                          | tuser        | tlast
//   in_     | in  | [12:0] byte_address, [20:13]   | [1:0] command| -
//           |     | data_byte, [23:21] zero        |              |
//   out_    | out | [7:0] read_byte                | -            | copy_done
//   cfg_    | in  | cfg_index selects, cfg_wdata carries the register value
//
// Read passes ST_READ; source passes ST_RD0, ST_MW0, ST_MW1 (read-modify-write of two
// destination bytes through the single read and single write port); all end in ST_FIN.
// One word is in flight at a time; in_tready is high only when the
// controller is idle. A result waits in the output register while the next
// word is accepted; a stalled output holds the controller in its last state.
// Reset is synchronous; the bitmap memory is not cleared.
module mono_bitmap_clipped_blit
  import mbb_pkg::*;
#(
  parameter int DEST_BYTES = DEST_BYTES_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [23:0]           in_tdata,   // [12:0] byte_address, [20:13] data_byte
  input  logic [1:0]            in_tuser,   // [1:0] command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [7:0]            out_tdata,  // [7:0] read_byte
  output logic                  out_tlast,  // copy_done
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(DEST_BYTES);

  state_t      state_r, state_nxt;
  cfg_t        cfg_r;
  pix_t        pix;

  cmd_t        in_cmd;
  logic [12:0] in_addr;
  logic [7:0]  in_data;
  logic [16:0] in_addr_w;
  logic        in_fire, in_in_range;

  logic [16:0] a0, a1;
  logic        en0, en1;

  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_wdata, mem_rdata;

  logic        in_range_r;
  logic        src_item_r;
  logic [7:0]  res_byte_r;
  logic        out_valid_r, out_last_r;
  logic [7:0]  out_byte_r;
  logic        out_free, out_load;

  assign in_cmd      = cmd_t'(in_tuser);
  assign in_addr     = in_tdata[12:0];
  assign in_data     = in_tdata[20:13];
  assign in_addr_w   = {4'b0000, in_addr};
  assign in_in_range = 32'(in_addr) < DEST_BYTES;
  assign in_fire     = in_tvalid && in_tready;

  // destination addresses of the two bytes a source word can touch
  assign a0  = {1'b0, pix.row_off} + {9'd0, pix.col0};
  assign a1  = {1'b0, pix.row_off} + {9'd0, pix.col1};
  assign en0 = (pix.mask0 != 8'h00) && (32'(a0) < DEST_BYTES);
  assign en1 = (pix.mask1 != 8'h00) && (32'(a1) < DEST_BYTES);

  assign out_free = !out_valid_r || out_tready;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_width  <= 10'd512;
      cfg_r.dest_height <= 8'd128;
      cfg_r.copy_width  <= 10'd8;
      cfg_r.copy_height <= 10'd1;
      cfg_r.pos_x       <= 10'd0;
      cfg_r.pos_y       <= 10'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEST_WIDTH:  cfg_r.dest_width  <= cfg_wdata;
        REG_DEST_HEIGHT: cfg_r.dest_height <= cfg_wdata[7:0];
        REG_COPY_WIDTH:  cfg_r.copy_width  <= cfg_wdata;
        REG_COPY_HEIGHT: cfg_r.copy_height <= cfg_wdata;
        REG_POS_X:       cfg_r.pos_x       <= cfg_wdata;
        REG_POS_Y:       cfg_r.pos_y       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  mbb_src_walk #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .step    (in_fire && (in_cmd == CMD_SOURCE)),
    .restart (in_fire && (in_cmd == CMD_RESTART)),
    .data    (in_data),
    .pix     (pix)
  );

  mbb_dest_ram #(
    .DEPTH (DEST_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_cmd)
            CMD_READ:   state_nxt = ST_READ;
            CMD_SOURCE: state_nxt = ST_RD0;
            default:    state_nxt = ST_FIN;
          endcase
        end
      end
      ST_READ: state_nxt = ST_FIN;
      ST_RD0:  state_nxt = ST_MW0;
      ST_MW0:  state_nxt = ST_MW1;
      ST_MW1:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // controller outputs
  always_comb begin
    in_tready = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = in_addr_w[AW-1:0];
    mem_wdata = in_data;
    mem_raddr = in_addr_w[AW-1:0];
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        mem_we    = in_tvalid && (in_cmd == CMD_WRITE) && in_in_range;
      end
      ST_RD0: begin
        mem_raddr = a0[AW-1:0];
      end
      ST_MW0: begin
        mem_we    = en0;
        mem_waddr = a0[AW-1:0];
        mem_wdata = (mem_rdata & ~pix.mask0) | (pix.bits0 & pix.mask0);
        mem_raddr = a1[AW-1:0];
      end
      ST_MW1: begin
        mem_we    = en1;
        mem_waddr = a1[AW-1:0];
        mem_wdata = (mem_rdata & ~pix.mask1) | (pix.bits1 & pix.mask1);
      end
      ST_FIN: begin
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_range_r <= in_in_range;
      src_item_r <= (in_cmd == CMD_SOURCE);
      res_byte_r <= 8'h00;
    end else if (state_r == ST_READ) begin
      res_byte_r <= in_range_r ? mem_rdata : 8'h00;
    end
    if (out_load) begin
      out_byte_r <= res_byte_r;
      out_last_r <= src_item_r && pix.done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

endmodule

[bench/tb.sv]
// Testbench for mono_bitmap_clipped_blit: primes bitmap bytes before first use, then runs
// directed and random blit sequences under several idle/stall mixes, checking every output
// word against a built-in bitmap model. Depends on mbb_pkg and the RTL under src/.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mbb_pkg::*;

  localparam int DEST_BYTES    = DEST_BYTES_DEF;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       copy_done;
  } blit_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [23:0]           in_tdata = '0;   // [12:0] byte_address, [20:13] data_byte
  logic [1:0]            in_tuser = '0;   // [1:0] command
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;       // [7:0] read_byte
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mono_bitmap_clipped_blit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // bitmap model
  logic [7:0] bitmap [DEST_BYTES];
  bit         written [DEST_BYTES];
  logic [9:0] m_dest_w, m_copy_w, m_copy_h, m_pos_x, m_pos_y;
  logic [7:0] m_dest_h;
  logic [8:0] src_row;
  logic [5:0] src_byte;

  blit_result_t pending_results [$];

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  int hold_req      = 0;
  int hold_left     = 0;
  int errors        = 0;
  int items_sent    = 0;
  int cycles        = 0;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic void plot_pixel(int dx, int dy, logic v);
    int dw, dh, stride, addr;
    dw = m_dest_w;
    dh = m_dest_h;
    if (dw > MAX_WIDTH_DEF) dw = MAX_WIDTH_DEF;
    if (dh > MAX_HEIGHT_DEF) dh = MAX_HEIGHT_DEF;
    if (dx < 0 || dy < 0 || dx >= dw || dy >= dh) return;
    stride = ((dw + 31) / 32) * 4;
    addr = dy * stride + (dx >> 3);
    if (addr >= DEST_BYTES) return;
    bitmap[addr][7 - (dx & 7)] = v;
  endfunction

  // Places one source word and advances the row/byte counters; returns copy_done.
  function automatic logic blit_source_word(logic [7:0] data);
    int cw, ch, bpr, rows, px, py, r, bc, c;
    logic fin;
    cw = m_copy_w;
    ch = m_copy_h;
    if (cw > 512) cw = 512;
    if (ch > 512) ch = 512;
    bpr = (cw + 7) / 8;
    if (bpr == 0) bpr = 1;
    rows = (ch == 0) ? 1 : ch;
    px = $signed(m_pos_x);
    py = $signed(m_pos_y);
    r = src_row;
    bc = src_byte;
    fin = 1'b0;
    if (r < ch) begin
      for (int b = 0; b < 8; b++) begin
        c = bc * 8 + b;
        if (c < cw) plot_pixel(px + c, py + r, data[7 - b]);
      end
    end
    // counters left past a shrunk geometry close the row / the copy
    if (bc + 1 >= bpr) begin
      src_byte = '0;
      if (r + 1 >= rows) begin
        src_row = '0;
        fin = 1'b1;
      end else begin
        src_row = 9'(r + 1);
      end
    end else begin
      src_byte = 6'(bc + 1);
    end
    return fin;
  endfunction

  function automatic blit_result_t predict_word(cmd_t cmd, logic [12:0] addr,
                                                logic [7:0] data);
    blit_result_t res;
    res = '0;
    case (cmd)
      CMD_WRITE: begin
        bitmap[addr] = data;
        written[addr] = 1'b1;
      end
      CMD_READ:   res.read_byte = bitmap[addr];
      CMD_SOURCE: res.copy_done = blit_source_word(data);
      default: begin
        src_row = '0;
        src_byte = '0;
      end
    endcase
    return res;
  endfunction

  // receiver: random stalls, or a long counted hold-off when requested
  always @(negedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin : check_out
    blit_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected word, expected none, got read_byte %02h copy_done %0b",
                 $time, out_tdata, out_tlast);
      end else begin
        want = pending_results.pop_front();
        if (out_tdata !== want.read_byte) begin
          errors++;
          $display("%0t ns: read_byte expected %02h, got %02h",
                   $time, want.read_byte, out_tdata);
        end
        if (out_tlast !== want.copy_done) begin
          errors++;
          $display("%0t ns: copy_done expected %0b, got %0b",
                   $time, want.copy_done, out_tlast);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_word(cmd_t cmd, logic [12:0] addr, logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser = cmd;
    in_tdata = {3'b000, data, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_word(cmd, addr, data));
    items_sent++;
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [9:0] value);
    wait_idle();
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    case (idx)
      REG_DEST_WIDTH:  m_dest_w = value;
      REG_DEST_HEIGHT: m_dest_h = value[7:0];
      REG_COPY_WIDTH:  m_copy_w = value;
      REG_COPY_HEIGHT: m_copy_h = value;
      REG_POS_X:       m_pos_x = value;
      REG_POS_Y:       m_pos_y = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(int dw, int dh, int cw, int ch, int px, int py);
    write_reg(REG_DEST_WIDTH, 10'(dw));
    write_reg(REG_DEST_HEIGHT, 10'(dh));
    write_reg(REG_COPY_WIDTH, 10'(cw));
    write_reg(REG_COPY_HEIGHT, 10'(ch));
    write_reg(REG_POS_X, 10'(px));
    write_reg(REG_POS_Y, 10'(py));
  endtask

  task automatic set_traffic(int idle_pct, int stall_pct);
    wait_idle();
    send_idle_pct = idle_pct;
    rcv_stall_pct = stall_pct;
  endtask

  function automatic logic [12:0] any_addr();
    return 13'($urandom_range(DEST_BYTES - 1));
  endfunction

  function automatic logic [7:0] any_byte();
    return 8'($urandom_range(255));
  endfunction

  // a byte gets a known value before any read or merge can see it
  task automatic prime_byte(logic [12:0] addr);
    if (!written[addr]) send_word(CMD_WRITE, addr, any_byte());
  endtask

  // primes every destination byte a copy with this clamped geometry can touch
  task automatic prime_window(int dw_e, int dh_e, int cw_e, int ch_e, int px, int py);
    int stride, x0, x1, y0, y1;
    stride = ((dw_e + 31) / 32) * 4;
    x0 = (px < 0) ? 0 : px;
    x1 = (px + cw_e > dw_e) ? dw_e - 1 : px + cw_e - 1;
    y0 = (py < 0) ? 0 : py;
    y1 = (py + ch_e > dh_e) ? dh_e - 1 : py + ch_e - 1;
    if (x0 > x1) return;
    for (int y = y0; y <= y1; y++) begin
      for (int bx = x0 >> 3; bx <= (x1 >> 3); bx++) begin
        if (y * stride + bx < DEST_BYTES) prime_byte(13'(y * stride + bx));
      end
    end
  endtask

  task automatic send_read(logic [12:0] addr);
    prime_byte(addr);
    send_word(CMD_READ, addr, any_byte());
  endtask

  task automatic send_noise();
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) send_word(CMD_WRITE, any_addr(), any_byte());
    else if (pick < 90) send_read(any_addr());
    else send_word(CMD_RESTART, any_addr(), any_byte());
  endtask

  task automatic test_byte_access();
    send_word(CMD_WRITE, 13'd0, 8'hff);
    send_word(CMD_WRITE, 13'(DEST_BYTES - 1), 8'h00);
    send_word(CMD_READ, 13'd0, 8'h00);
    send_word(CMD_READ, 13'(DEST_BYTES - 1), 8'hff);
  endtask

  // reset geometry: one 8-pixel row at the origin, done on the only word
  task automatic test_default_copy();
    send_word(CMD_SOURCE, any_addr(), 8'ha5);
    send_word(CMD_READ, 13'd0, any_byte());
  endtask

  task automatic test_clipping();
    // left edge cut at x=-3, second source row falls below the bitmap
    set_geometry(20, 3, 13, 2, -3, 2);
    prime_window(20, 3, 13, 2, -3, 2);
    send_word(CMD_RESTART, any_addr(), any_byte());
    repeat (4) send_word(CMD_SOURCE, any_addr(), any_byte());
    send_word(CMD_READ, 13'd8, any_byte());
    send_word(CMD_READ, 13'd9, any_byte());
    // zero-width bitmap drops everything
    set_geometry(0, 3, 8, 1, 0, 0);
    send_word(CMD_SOURCE, any_addr(), 8'hff);
    send_word(CMD_READ, 13'd0, any_byte());
    // zero copy size: one word, no pixel
    set_geometry(20, 3, 0, 0, 0, 0);
    send_word(CMD_SOURCE, any_addr(), 8'h00);
  endtask

  task automatic test_geometry_change();
    set_geometry(64, 16, 24, 3, 0, 0);
    prime_window(64, 16, 24, 3, 0, 0);
    send_word(CMD_RESTART, any_addr(), any_byte());
    repeat (4) send_word(CMD_SOURCE, any_addr(), any_byte());
    // byte counter now past the narrower row
    write_reg(REG_COPY_WIDTH, 10'd8);
    send_word(CMD_SOURCE, any_addr(), any_byte());
    // row counter now past the shorter copy
    write_reg(REG_COPY_HEIGHT, 10'd1);
    send_word(CMD_SOURCE, any_addr(), any_byte());
    // restart in the middle of a copy
    write_reg(REG_COPY_WIDTH, 10'd16);
    send_word(CMD_SOURCE, any_addr(), any_byte());
    send_word(CMD_RESTART, any_addr(), any_byte());
    send_word(CMD_SOURCE, any_addr(), any_byte());
    send_word(CMD_SOURCE, any_addr(), any_byte());
    send_word(CMD_READ, 13'd0, any_byte());
    send_word(CMD_READ, 13'd8, any_byte());
  endtask

  task automatic run_blit_sequence();
    int dw, dh, cw, ch, px, py, pick;
    int dw_e, dh_e, cw_e, ch_e, bpr, rows, n_words, stop_at, stride, dx, dy, addr;
    logic [7:0] data;
    pick = $urandom_range(99);
    if (pick < 4) dw = 0;
    else if (pick < 8) dw = $urandom_range(1023, 513);
    else if (pick < 12) dw = 512;
    else dw = $urandom_range(512, 1);
    pick = $urandom_range(99);
    if (pick < 4) dh = 0;
    else if (pick < 8) dh = $urandom_range(255, 129);
    else if (pick < 12) dh = 128;
    else dh = $urandom_range(128, 1);
    pick = $urandom_range(99);
    if (pick < 4) cw = 0;
    else if (pick < 8) cw = $urandom_range(1023, 513);
    else if (pick < 20) cw = $urandom_range(512, 41);
    else cw = $urandom_range(40, 1);
    pick = $urandom_range(99);
    if (cw > 40) ch = $urandom_range(2, 1);
    else if (pick < 3) ch = 0;
    else if (pick < 5 && cw <= 8) ch = $urandom_range(1023, 513);
    else ch = $urandom_range(8, 1);
    dw_e = (dw > 512) ? 512 : dw;
    dh_e = (dh > 128) ? 128 : dh;
    cw_e = (cw > 512) ? 512 : cw;
    ch_e = (ch > 512) ? 512 : ch;
    if ($urandom_range(99) < 30) begin
      px = $urandom_range(1023);
      py = $urandom_range(1023);
      if (px >= 512) px -= 1024;
      if (py >= 512) py -= 1024;
    end else begin
      px = clamp($urandom_range(dw_e + cw_e + 16) - cw_e - 8, -512, 511);
      py = clamp($urandom_range(dh_e + ch_e + 4) - ch_e - 2, -512, 511);
    end
    set_geometry(dw, dh, cw, ch, px, py);
    prime_window(dw_e, dh_e, cw_e, ch_e, px, py);
    if ($urandom_range(99) < 80) send_word(CMD_RESTART, any_addr(), any_byte());
    bpr = (cw_e + 7) / 8;
    if (bpr == 0) bpr = 1;
    rows = (ch_e == 0) ? 1 : ch_e;
    n_words = bpr * rows;
    stop_at = ($urandom_range(99) < 10) ? $urandom_range(n_words - 1) : n_words;
    for (int i = 0; i < stop_at; i++) begin
      if ($urandom_range(99) < 8) send_noise();
      pick = $urandom_range(99);
      data = (pick < 5) ? 8'h00 : (pick < 10) ? 8'hff : any_byte();
      send_word(CMD_SOURCE, any_addr(), data);
    end
    // read back around the copy window
    stride = ((dw_e + 31) / 32) * 4;
    repeat (6) begin
      if (dw_e == 0 || dh_e == 0) begin
        addr = any_addr();
      end else begin
        dy = clamp(py + $urandom_range(rows - 1), 0, dh_e - 1);
        dx = clamp(px + $urandom_range(cw_e + 8) - 4, 0, dw_e - 1);
        addr = dy * stride + (dx >> 3);
      end
      send_read(13'(addr));
    end
  endtask

  // receiver holds off while words keep coming, so the input side must stall
  task automatic test_output_hold();
    set_traffic(0, 0);
    hold_req = 300;
    repeat (16) send_read(any_addr());
    run_blit_sequence();
  endtask

  task automatic test_random_copies(int quota);
    int start;
    start = items_sent;
    while (items_sent - start < quota) run_blit_sequence();
  endtask

  initial begin
    m_dest_w = 10'd512;
    m_dest_h = 8'd128;
    m_copy_w = 10'd8;
    m_copy_h = 10'd1;
    m_pos_x = '0;
    m_pos_y = '0;
    src_row = '0;
    src_byte = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    test_byte_access();
    test_default_copy();
    test_clipping();
    test_geometry_change();
    test_output_hold();
    set_traffic(0, 0);
    test_random_copies(375);
    set_traffic(81, 0);
    test_random_copies(375);
    set_traffic(0, 81);
    test_random_copies(375);
    set_traffic(14, 14);
    test_random_copies(375);
    wait_idle();
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
src/mbb_pkg.sv
src/mbb_dest_ram.sv
src/mbb_src_walk.sv
src/mono_bitmap_clipped_blit.sv
bench/tb.sv
